### src/nrgfe_pkg.sv
// Shared types and constants for the NMEA RMC/GGA field extractor.
`default_nettype none

package nrgfe_pkg;

	localparam int unsigned ACC_W     = 32;
	localparam int unsigned CNT_W     = 6;
	localparam int unsigned FIELD_W   = 6;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

	// sentence characters
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RMC_SPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RMC_DATE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GGA_TIME  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GGA_SATS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GGA_HDOP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GGA_ALT   = 3'd5;

	typedef enum logic [2:0] {
		OP_CHAR      = 3'd0,
		OP_BEGIN_RMC = 3'd1,
		OP_BEGIN_GGA = 3'd2,
		OP_ACK_ALT   = 3'd3,
		OP_ACK_SPEED = 3'd4
	} op_t;

	typedef struct packed {
		logic [FIELD_W-1:0] rmc_speed;
		logic [FIELD_W-1:0] rmc_date;
		logic [FIELD_W-1:0] gga_time;
		logic [FIELD_W-1:0] gga_sats;
		logic [FIELD_W-1:0] gga_hdop;
		logic [FIELD_W-1:0] gga_alt;
	} cfg_t;

	// one result word; time_acc is the undivided time until the divide stage
	typedef struct packed {
		logic [ACC_W-1:0] speed;
		logic [ACC_W-1:0] date;
		logic [ACC_W-1:0] time_acc;
		logic [ACC_W-1:0] sats;
		logic [ACC_W-1:0] hdop;
		logic [ACC_W-1:0] alt;
		logic             new_speed;
		logic             new_alt;
		logic             date_valid;
		logic             in_rmc;
		logic             in_gga;
	} res_t;

endpackage

`default_nettype wire

### src/nrgfe_cfg.sv
// Field position registers written through the configuration port.
`default_nettype none

module nrgfe_cfg
	import nrgfe_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [FIELD_W-1:0]   wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rmc_speed <= 6'd8;
			cfg_q.rmc_date  <= 6'd10;
			cfg_q.gga_time  <= 6'd2;
			cfg_q.gga_sats  <= 6'd8;
			cfg_q.gga_hdop  <= 6'd9;
			cfg_q.gga_alt   <= 6'd10;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_RMC_SPEED: cfg_q.rmc_speed <= wr_data;
				CFG_RMC_DATE:  cfg_q.rmc_date  <= wr_data;
				CFG_GGA_TIME:  cfg_q.gga_time  <= wr_data;
				CFG_GGA_SATS:  cfg_q.gga_sats  <= wr_data;
				CFG_GGA_HDOP:  cfg_q.gga_hdop  <= wr_data;
				CFG_GGA_ALT:   cfg_q.gga_alt   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### src/nrgfe_parse.sv
// Input register, sentence parsing state and capture logic.
`default_nettype none

module nrgfe_parse
	import nrgfe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] op,
	input  wire logic [7:0] char_in,
	input  cfg_t            cfg,
	output logic            res_valid,
	input  wire logic       res_ready,
	output res_t            res
);

	logic       v_s1;
	logic [2:0] op_s1;
	logic [7:0] char_s1;
	logic       v_s2;

	logic             mode_rmc_q, mode_gga_q, digit_seen_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] speed_q, date_q, time_q, sats_q, hdop_q, alt_q;
	logic             new_speed_q, new_alt_q, date_valid_q;

	logic             mode_rmc_d, mode_gga_d, digit_seen_d;
	logic [CNT_W-1:0] cnt_d, cnt_inc;
	logic [ACC_W-1:0] acc_d, acc_x10;
	logic [ACC_W-1:0] speed_d, date_d, time_d, sats_d, hdop_d, alt_d;
	logic             new_speed_d, new_alt_d, date_valid_d;
	logic             is_digit;

	logic ready_s1, ready_s2, fire_s1;

	assign ready_s2 = !v_s2 || res_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign fire_s1  = v_s1 && ready_s2;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= in_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			op_s1   <= op;
			char_s1 <= char_in;
		end
	end

	// digits '0'..'9' sit at 0x30..0x39, so the low nibble is the value
	assign is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign acc_x10  = {acc_q[ACC_W-4:0], 3'b000} + {acc_q[ACC_W-2:0], 1'b0};
	assign cnt_inc  = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		mode_rmc_d   = mode_rmc_q;
		mode_gga_d   = mode_gga_q;
		digit_seen_d = digit_seen_q;
		cnt_d        = cnt_q;
		acc_d        = acc_q;
		speed_d      = speed_q;
		date_d       = date_q;
		time_d       = time_q;
		sats_d       = sats_q;
		hdop_d       = hdop_q;
		alt_d        = alt_q;
		new_speed_d  = new_speed_q;
		new_alt_d    = new_alt_q;
		date_valid_d = date_valid_q;
		unique case (op_t'(op_s1))
			OP_CHAR: begin
				if (char_s1 == CH_STAR) begin
					mode_rmc_d = 1'b0;
					mode_gga_d = 1'b0;
				end else if (mode_rmc_q || mode_gga_q) begin
					if (char_s1 == CH_COMMA) begin
						cnt_d = cnt_inc;
						if (digit_seen_q) begin
							if (mode_rmc_q) begin
								if (cnt_inc == cfg.rmc_speed) begin
									speed_d     = acc_q;
									new_speed_d = 1'b1;
								end else if (cnt_inc == cfg.rmc_date) begin
									date_d       = acc_q;
									date_valid_d = 1'b1;
								end
							end else begin
								if (cnt_inc == cfg.gga_time) begin
									time_d = acc_q;
								end else if (cnt_inc == cfg.gga_sats) begin
									sats_d = acc_q;
								end else if (cnt_inc == cfg.gga_hdop) begin
									hdop_d = acc_q;
								end else if (cnt_inc == cfg.gga_alt) begin
									alt_d     = acc_q;
									new_alt_d = 1'b1;
								end
							end
						end
						acc_d        = '0;
						digit_seen_d = 1'b0;
					end else if (is_digit) begin
						acc_d        = acc_x10 + {{(ACC_W-4){1'b0}}, char_s1[3:0]};
						digit_seen_d = 1'b1;
					end
				end
			end
			OP_BEGIN_RMC: begin
				cnt_d        = '0;
				acc_d        = '0;
				digit_seen_d = 1'b0;
				mode_rmc_d   = 1'b1;
			end
			OP_BEGIN_GGA: begin
				cnt_d        = '0;
				acc_d        = '0;
				digit_seen_d = 1'b0;
				mode_gga_d   = 1'b1;
			end
			OP_ACK_ALT:   new_alt_d   = 1'b0;
			OP_ACK_SPEED: new_speed_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_rmc_q   <= 1'b0;
			mode_gga_q   <= 1'b0;
			digit_seen_q <= 1'b0;
			cnt_q        <= '0;
			acc_q        <= '0;
			speed_q      <= '0;
			date_q       <= '0;
			time_q       <= '0;
			sats_q       <= '0;
			hdop_q       <= '0;
			alt_q        <= '0;
			new_speed_q  <= 1'b0;
			new_alt_q    <= 1'b0;
			date_valid_q <= 1'b0;
		end else if (fire_s1) begin
			mode_rmc_q   <= mode_rmc_d;
			mode_gga_q   <= mode_gga_d;
			digit_seen_q <= digit_seen_d;
			cnt_q        <= cnt_d;
			acc_q        <= acc_d;
			speed_q      <= speed_d;
			date_q       <= date_d;
			time_q       <= time_d;
			sats_q       <= sats_d;
			hdop_q       <= hdop_d;
			alt_q        <= alt_d;
			new_speed_q  <= new_speed_d;
			new_alt_q    <= new_alt_d;
			date_valid_q <= date_valid_d;
		end
	end

	// state only moves when a word enters stage 2, so the state registers
	// are the stage 2 result word
	assign res_valid      = v_s2;
	assign res.speed      = speed_q;
	assign res.date       = date_q;
	assign res.time_acc   = time_q;
	assign res.sats       = sats_q;
	assign res.hdop       = hdop_q;
	assign res.alt        = alt_q;
	assign res.new_speed  = new_speed_q;
	assign res.new_alt    = new_alt_q;
	assign res.date_valid = date_valid_q;
	assign res.in_rmc     = mode_rmc_q;
	assign res.in_gga     = mode_gga_q;

endmodule

`default_nettype wire

### src/nrgfe_tdiv.sv
// Two-stage divide of the GGA time by a constant, ending in the output register.
`default_nettype none

module nrgfe_tdiv
	import nrgfe_pkg::*;
#(
	parameter int unsigned TIME_DIVISOR = 100
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  res_t      in_res,
	output logic      out_valid,
	input  wire logic out_stall,
	output res_t      out_res
);

	// q = floor(x * M / 2^(32+L)), M = floor(2^(32+L)/D) + 1, exact for 32-bit x
	localparam int unsigned SHIFT_L  = $clog2(TIME_DIVISOR);
	localparam logic [63:0] MAGIC    =
		((64'd1 << (ACC_W + SHIFT_L)) / 64'(TIME_DIVISOR)) + 64'd1;
	localparam logic             MAGIC_HI = MAGIC[ACC_W];
	localparam logic [ACC_W-1:0] MAGIC_LO = MAGIC[ACC_W-1:0];
	localparam int unsigned SUM_W    = 2 * ACC_W + SHIFT_L + 1;

	logic               v_s3, v_s4;
	res_t               res_s3, res_s4, res_div;
	logic [2*ACC_W-1:0] prod_s3;
	logic [SUM_W-1:0]   sum;
	logic [ACC_W-1:0]   quot;
	logic               ready_s3, ready_s4;

	assign ready_s4 = !v_s4 || !out_stall;
	assign ready_s3 = !v_s3 || ready_s4;
	assign in_ready = ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ready_s3) begin
				v_s3 <= in_valid;
			end
			if (ready_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s3) begin
			res_s3  <= in_res;
			prod_s3 <= {{ACC_W{1'b0}}, in_res.time_acc} * {{ACC_W{1'b0}}, MAGIC_LO};
		end
	end

	assign sum  = SUM_W'(prod_s3)
		+ (MAGIC_HI ? (SUM_W'(res_s3.time_acc) << ACC_W) : {SUM_W{1'b0}});
	assign quot = sum[ACC_W + SHIFT_L +: ACC_W];

	always_comb begin
		res_div          = res_s3;
		res_div.time_acc = quot;
	end

	always_ff @(posedge clk) begin
		if (v_s3 && ready_s4) begin
			res_s4 <= res_div;
		end
	end

	assign out_valid = v_s4;
	assign out_res   = res_s4;

endmodule

`default_nettype wire

### src/nmea_rmc_gga_field_extractor.sv
// Top level of the NMEA RMC/GGA field extractor.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------------
//  input   | in        | in_valid / in_stall  | op, char_in
//  output  | out       | out_valid / out_stall| speed_raw .. alt_raw, flags, modes
//  config  | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low; a result word passes through the
// input register, parse state, time multiply and add-and-shift output register in
// that order.
// Reset clears all parse state, captured values and flags, and loads the
// default field positions; no clearing pass follows.
// A stalled output fills the empty stages first; in_stall rises only when all
// four stages hold words. cfg_ready is always high.
`default_nettype none

module nmea_rmc_gga_field_extractor
	import nrgfe_pkg::*;
#(
	parameter int unsigned TIME_DIVISOR = 100
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [2:0]           op,
	input  wire logic [7:0]           char_in,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [31:0]               speed_raw,
	output logic [31:0]               date_raw,
	output logic [31:0]               time_raw,
	output logic [31:0]               sat_count,
	output logic [31:0]               hdop_raw,
	output logic [31:0]               alt_raw,
	output logic                      new_speed,
	output logic                      new_alt,
	output logic                      date_valid,
	output logic                      in_rmc,
	output logic                      in_gga,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FIELD_W-1:0]   cfg_data
);

	cfg_t cfg;
	res_t parse_res, out_res;
	logic parse_valid, div_ready;

	assign cfg_ready = 1'b1;

	nrgfe_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	nrgfe_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.char_in   (char_in),
		.cfg       (cfg),
		.res_valid (parse_valid),
		.res_ready (div_ready),
		.res       (parse_res)
	);

	nrgfe_tdiv #(
		.TIME_DIVISOR (TIME_DIVISOR)
	) u_tdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (parse_valid),
		.in_ready  (div_ready),
		.in_res    (parse_res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign speed_raw  = out_res.speed;
	assign date_raw   = out_res.date;
	assign time_raw   = out_res.time_acc;
	assign sat_count  = out_res.sats;
	assign hdop_raw   = out_res.hdop;
	assign alt_raw    = out_res.alt;
	assign new_speed  = out_res.new_speed;
	assign new_alt    = out_res.new_alt;
	assign date_valid = out_res.date_valid;
	assign in_rmc     = out_res.in_rmc;
	assign in_gga     = out_res.in_gga;

endmodule

`default_nettype wire

### src/nrgfe_chk.sv
// Port-level checker for the field extractor, bound to the top level.
`default_nettype none

module nrgfe_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] speed_raw,
	input wire logic [31:0] time_raw,
	input wire logic [31:0] alt_raw,
	input wire logic        new_speed,
	input wire logic        new_alt,
	input wire logic        date_valid,
	input wire logic        in_rmc,
	input wire logic        in_gga
);

	logic        out_take;
	logic        prev_new_speed_q, prev_new_alt_q;
	logic [31:0] prev_speed_q;

	assign out_take = out_valid && !out_stall;

	// last word taken at the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_new_speed_q <= 1'b0;
			prev_new_alt_q   <= 1'b0;
			prev_speed_q     <= '0;
		end else if (out_take) begin
			prev_new_speed_q <= new_speed;
			prev_new_alt_q   <= new_alt;
			prev_speed_q     <= speed_raw;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(speed_raw)
			&& $stable(time_raw) && $stable(alt_raw) && $stable(date_valid))
		else $error("stalled output word changed");

	a_date_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && date_valid |=> !out_valid || date_valid)
		else $error("date_valid dropped");

	a_alt_needs_gga: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_alt && !prev_new_alt_q |-> in_gga && !in_rmc)
		else $error("altitude captured outside GGA mode");

	a_speed_needs_rmc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((new_speed && !prev_new_speed_q) || (speed_raw != prev_speed_q))
			|-> in_rmc && new_speed)
		else $error("speed captured outside RMC mode");

endmodule

bind nmea_rmc_gga_field_extractor nrgfe_chk u_chk (.*);

`default_nettype wire

### bench/nmea_rmc_gga_field_extractor_test.sv
// Testbench for the NMEA RMC/GGA field extractor: sentence stimulus, parser model, word checks.
`timescale 1ns / 100ps

module nmea_rmc_gga_field_extractor_test;
	import nrgfe_pkg::*;

	localparam int unsigned TIME_DIV = 100;
	// op codes the block ignores
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int PHASES = 6;
	localparam int WORDS_PER_PHASE = 250;
	localparam int HOLD_CYCLES = 150;

	typedef struct packed {
		logic [2:0] code;
		logic [7:0] ch;
	} word_t;

	typedef struct {
		logic [31:0] speed;
		logic [31:0] date;
		logic [31:0] utc;
		logic [31:0] sats;
		logic [31:0] hdop;
		logic [31:0] alt;
		logic        new_speed;
		logic        new_alt;
		logic        date_valid;
		logic        in_rmc;
		logic        in_gga;
	} fix_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] op;
	logic [7:0] char_in;
	logic out_valid;
	logic out_stall;
	logic [31:0] speed_raw, date_raw, time_raw, sat_count, hdop_raw, alt_raw;
	logic new_speed, new_alt, date_valid, in_rmc, in_gga;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FIELD_W-1:0] cfg_data;

	word_t word_q[$];
	fix_t fix_q[$];
	word_t next_word;
	int sent_words = 0;
	int errors = 0;
	int n_checked = 0;
	int hold_left = 0;
	int send_gap_pct = 0;
	int recv_gap_pct = 0;

	// parser model state
	logic [5:0] pos [0:5] = '{6'd8, 6'd10, 6'd2, 6'd8, 6'd9, 6'd10};
	logic rmc_on = 1'b0;
	logic gga_on = 1'b0;
	logic have_digit = 1'b0;
	logic [5:0] field_no = '0;
	logic [31:0] num_acc = '0;
	logic [31:0] speed_q = '0, date_q = '0, utc_q = '0, sats_q = '0, hdop_q = '0, alt_q = '0;
	logic speed_flag = 1'b0, alt_flag = 1'b0, date_flag = 1'b0;

	nmea_rmc_gga_field_extractor #(.TIME_DIVISOR(TIME_DIV)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .char_in(char_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.speed_raw(speed_raw), .date_raw(date_raw), .time_raw(time_raw),
		.sat_count(sat_count), .hdop_raw(hdop_raw), .alt_raw(alt_raw),
		.new_speed(new_speed), .new_alt(new_alt), .date_valid(date_valid),
		.in_rmc(in_rmc), .in_gga(in_gga),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the parser by one word and queue the fix it leaves behind
	function automatic void parse_word(input logic [2:0] code, input logic [7:0] ch);
		fix_t f;
		case (code)
			OP_CHAR: begin
				if (ch == CH_STAR) begin
					rmc_on = 1'b0;
					gga_on = 1'b0;
				end
				if (rmc_on || gga_on) begin
					if (ch == CH_COMMA) begin
						if (field_no != CNT_MAX)
							field_no = field_no + 6'd1;
						if (have_digit) begin
							if (rmc_on) begin
								if (field_no == pos[CFG_RMC_SPEED]) begin
									speed_q = num_acc;
									speed_flag = 1'b1;
								end else if (field_no == pos[CFG_RMC_DATE]) begin
									date_q = num_acc;
									date_flag = 1'b1;
								end
							end else begin
								if (field_no == pos[CFG_GGA_TIME])
									utc_q = num_acc / TIME_DIV;
								else if (field_no == pos[CFG_GGA_SATS])
									sats_q = num_acc;
								else if (field_no == pos[CFG_GGA_HDOP])
									hdop_q = num_acc;
								else if (field_no == pos[CFG_GGA_ALT]) begin
									alt_q = num_acc;
									alt_flag = 1'b1;
								end
							end
						end
						num_acc = '0;
						have_digit = 1'b0;
					end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
						num_acc = num_acc * 32'd10 + 32'(ch - CH_ZERO);
						have_digit = 1'b1;
					end
				end
			end
			OP_BEGIN_RMC, OP_BEGIN_GGA: begin
				field_no = '0;
				num_acc = '0;
				have_digit = 1'b0;
				if (code == OP_BEGIN_RMC)
					rmc_on = 1'b1;
				else
					gga_on = 1'b1;
			end
			OP_ACK_ALT: alt_flag = 1'b0;
			OP_ACK_SPEED: speed_flag = 1'b0;
			default: ;
		endcase
		f.speed = speed_q;
		f.date = date_q;
		f.utc = utc_q;
		f.sats = sats_q;
		f.hdop = hdop_q;
		f.alt = alt_q;
		f.new_speed = speed_flag;
		f.new_alt = alt_flag;
		f.date_valid = date_flag;
		f.in_rmc = rmc_on;
		f.in_gga = gga_on;
		fix_q.push_back(f);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic compare_fix();
		fix_t want;
		if (fix_q.size() == 0) begin
			$error("result word with nothing expected");
			errors++;
		end else begin
			want = fix_q.pop_front();
			check_field("speed_raw", want.speed, speed_raw);
			check_field("date_raw", want.date, date_raw);
			check_field("time_raw", want.utc, time_raw);
			check_field("sat_count", want.sats, sat_count);
			check_field("hdop_raw", want.hdop, hdop_raw);
			check_field("alt_raw", want.alt, alt_raw);
			check_field("new_speed", want.new_speed, new_speed);
			check_field("new_alt", want.new_alt, new_alt);
			check_field("date_valid", want.date_valid, date_valid);
			check_field("in_rmc", want.in_rmc, in_rmc);
			check_field("in_gga", want.in_gga, in_gga);
		end
	endtask

	// driver: predicts on each accepted word, then offers the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				parse_word(op, char_in);
			if (!in_valid || !in_stall) begin
				if (word_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					next_word = word_q.pop_front();
					in_valid <= 1'b1;
					op <= next_word.code;
					char_in <= next_word.ch;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks result words; twice holds off long enough to back up the input
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				compare_fix();
				n_checked++;
				if (n_checked % 700 == 400)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_gap_pct);
			end
		end
	end

	task automatic write_pos(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		pos[idx] = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_word(input logic [2:0] code, input logic [7:0] ch);
		word_q.push_back('{code, ch});
		sent_words++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_word(OP_CHAR, s[i]);
	endtask

	task automatic queue_field();
		string decor;
		int n;
		int r;
		decor = ".-NSEWAM";
		r = $urandom_range(99);
		if (r < 20)
			n = 0;
		else if (r < 90)
			n = $urandom_range(1, 6);
		else
			n = $urandom_range(7, 12);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) == 0)
				queue_word(OP_CHAR, decor[$urandom_range(7)]);
			queue_word(OP_CHAR, 8'(CH_ZERO + $urandom_range(9)));
		end
		if ($urandom_range(19) == 0)
			queue_word(OP_CHAR, decor[$urandom_range(7)]);
		queue_word(OP_CHAR, CH_COMMA);
	endtask

	task automatic queue_sentence(input int min_fields, input int max_fields);
		string hex;
		logic [2:0] first;
		logic [2:0] other;
		int nf;
		hex = "0123456789ABCDEF";
		first = $urandom_range(1) ? OP_BEGIN_RMC : OP_BEGIN_GGA;
		other = (first == OP_BEGIN_RMC) ? OP_BEGIN_GGA : OP_BEGIN_RMC;
		queue_word(first, 8'($urandom));
		if ($urandom_range(9) == 0)
			queue_word(other, 8'($urandom));
		nf = $urandom_range(min_fields, max_fields);
		for (int i = 0; i < nf; i++) begin
			queue_field();
			if ($urandom_range(49) == 0)
				queue_word(first, 8'($urandom));
		end
		// mostly a proper '*' checksum tail; sometimes the sentence is cut short
		if ($urandom_range(9) != 0) begin
			if ($urandom_range(1))
				queue_field();
			queue_word(OP_CHAR, CH_STAR);
			queue_word(OP_CHAR, hex[$urandom_range(15)]);
			queue_word(OP_CHAR, hex[$urandom_range(15)]);
		end
		if ($urandom_range(3) == 0)
			queue_word(OP_ACK_SPEED, 8'($urandom));
		if ($urandom_range(3) == 0)
			queue_word(OP_ACK_ALT, 8'($urandom));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (word_q.size() != 0 || in_valid || fix_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_CHAR;
		char_in = 8'h00;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_RMC_SPEED;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: ; // reset positions
				1: for (int i = 0; i < 6; i++)
					write_pos(CFG_IDX_W'(i), 6'd1);
				2: for (int i = 0; i < 6; i++)
					write_pos(CFG_IDX_W'(i), CNT_MAX);
				default: begin
					write_pos(CFG_RMC_SPEED, 6'($urandom_range(1, 12)));
					write_pos(CFG_RMC_DATE, ph == 4 ? 6'd0 : 6'($urandom_range(1, 12)));
					write_pos(CFG_GGA_TIME, 6'($urandom_range(1, 12)));
					write_pos(CFG_GGA_SATS, 6'($urandom_range(1, 12)));
					write_pos(CFG_GGA_HDOP, 6'($urandom_range(1, 12)));
					write_pos(CFG_GGA_ALT, 6'($urandom_range(1, 12)));
				end
			endcase
			@(negedge clk);
			send_gap_pct = (ph < 2) ? 17 : (ph < 4) ? 53 : 0;
			recv_gap_pct = (ph < 2) ? 53 : (ph < 4) ? 17 : 0;
			if (ph == 0) begin
				queue_word(OP_ACK_SPEED, 8'h00);
				queue_word(OP_ACK_ALT, 8'hFF);
				queue_word(OP_SPARE_LO, 8'h00);
				queue_word(OP_SPARE_HI, 8'hFF);
				// characters and '*' while no sentence is open
				queue_word(OP_CHAR, "7");
				queue_word(OP_CHAR, CH_STAR);
				queue_word(OP_BEGIN_GGA, 8'h00);
				queue_text("1,");
				queue_word(OP_CHAR, 8'h00);
				queue_word(OP_CHAR, 8'hFF);
				// accumulator wraps before the time divide
				queue_text("99999999999,");
				// both modes open at once
				queue_word(OP_BEGIN_RMC, 8'hFF);
				queue_word(OP_CHAR, CH_STAR);
			end
			start = sent_words;
			while (sent_words - start < WORDS_PER_PHASE) begin
				if ($urandom_range(99) < 88) begin
					if (ph == 2)
						queue_sentence(55, 70);
					else
						queue_sentence(0, 14);
				end else begin
					repeat ($urandom_range(1, 5))
						queue_word(3'($urandom_range(7)), 8'($urandom));
				end
			end
			wait_drained();
		end
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
